// ----- rtl/fat12_cte_pkg.sv -----
// ----------------------------------------------------------------------------
// fat12_cte_pkg
// Shared types and constants of the FAT12 cluster table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fat12_cte_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int ROW_COUNT   = (MAX_ENTRIES + 1) / 2;
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int ROW_DATA_W  = 24;
    localparam int TABLE_BYTES = ROW_COUNT * 3;

    localparam int ENTRY_W  = 12;
    localparam int ACTION_W = 3;
    localparam int ADDR_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 13;

    localparam int RECIP_THIRD = 2731;
    localparam int RECIP_SHIFT = 13;
    localparam int PROD_W      = ADDR_W + 12;

    localparam logic [ENTRY_W-1:0] CLAIM_MARK  = 12'hFFF;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd2880;
    localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(ROW_COUNT - 1);

    localparam logic [ACTION_W-1:0] ACT_READ_ENTRY  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_ENTRY = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ALLOCATE    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE_BYTE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_BYTE   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ENTRY_W-1:0]  cluster;
        logic [ENTRY_W-1:0]  next_value;
        logic [ADDR_W-1:0]   byte_addr;
        logic [BYTE_W-1:0]   byte_data;
    } item_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_value;
        logic               found;
        logic [ENTRY_W-1:0] allocated_index;
        logic [BYTE_W-1:0]  byte_out;
    } res_t;

    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [ROW_W-1:0]      addr;
        logic [ROW_DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/fat12_cluster_table_engine_unit.sv -----
// Entry and byte actions: the row is read when the beat is taken, then modified or returned
// in the execute state into the output register. Allocate: rows are scanned from row 0 until
// a free entry below entry_count (capped at 4096) is claimed, or a miss returns found = 0.
// The single-port table row RAM serves one action at a time: a new beat is taken only in idle.
// The allocate scan reads one 24-bit row (two entries) per cycle.
// Reset: control cleared, entry_count = 2880; table contents undefined until loaded.
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine_unit
// FAT12 allocation table held as 2048 rows of three packed bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_table_engine_unit
    import fat12_cte_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,    // cluster, next_value, byte_addr, byte_data
    input  wire logic [2:0]   s_tuser,    // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,    // entry_value, allocated_index, byte_out
    output logic [0:0]        m_tuser,    // found
    input  wire logic         cfg_wr_en,
    input  wire logic [12:0]  cfg_wr_data
);

    item_t                 item;
    mem_req_t              mem_req;
    logic [ROW_DATA_W-1:0] mem_rd_data;
    logic                  res_valid;
    res_t                  res;
    logic                  slot_free;
    logic [2:0]            pad_unused;

    assign pad_unused      = s_tdata[47:45];
    assign item.action     = s_tuser;
    assign item.cluster    = s_tdata[11:0];
    assign item.next_value = s_tdata[23:12];
    assign item.byte_addr  = s_tdata[36:24];
    assign item.byte_data  = s_tdata[44:37] | (BYTE_W'(pad_unused) & '0);

    fat12_cte_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .slot_free   (slot_free)
    );

    fat12_cte_ram #(
        .ADDR_W (ROW_W),
        .DATA_W (ROW_DATA_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_req.rd_en),
        .wr_en   (mem_req.wr_en),
        .addr    (mem_req.addr),
        .wr_data (mem_req.wr_data),
        .rd_data (mem_rd_data)
    );

    fat12_cte_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/fat12_cte_ram.sv -----
// ----------------------------------------------------------------------------
// fat12_cte_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cte_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 24
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fat12_cte_core.sv -----
// ----------------------------------------------------------------------------
// fat12_cte_core
// Action sequencer: row address decode, read-modify-write and allocate scan.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cte_core
    import fat12_cte_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire item_t                 in_item,
    input  wire logic                  cfg_wr_en,
    input  wire logic [COUNT_W-1:0]    cfg_wr_data,
    output mem_req_t                   mem_req,
    input  wire logic [ROW_DATA_W-1:0] mem_rd_data,
    output logic                       res_valid,
    output res_t                       res,
    input  wire logic                  slot_free
);

    state_t               state_reg, state_next;
    logic [ACTION_W-1:0]  act_reg, act_next;
    logic                 odd_reg, odd_next;
    logic [ENTRY_W-1:0]   value_reg, value_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COUNT_W-1:0]   count_reg;

    logic [PROD_W-1:0]    prod;
    logic [ROW_W-1:0]     in_byte_row;
    logic [ADDR_W-1:0]    lane_diff;
    logic [1:0]           lane;
    logic                 addr_ok;
    logic [BYTE_W-1:0]    lane_byte;
    logic [ROW_DATA_W-1:0] byte_merged;
    logic [COUNT_W-1:0]   even_idx;
    logic [COUNT_W-1:0]   odd_idx;
    logic                 even_hit;
    logic                 odd_hit;
    logic                 scan_last;

    assign prod        = PROD_W'(in_item.byte_addr) * PROD_W'(RECIP_THIRD);
    assign in_byte_row = prod[RECIP_SHIFT +: ROW_W];

    assign lane_diff = addr_reg - (ADDR_W'({row_reg, 1'b0}) + ADDR_W'(row_reg));
    assign lane      = lane_diff[1:0];
    assign addr_ok   = addr_reg < ADDR_W'(TABLE_BYTES);

    assign even_idx  = COUNT_W'({row_reg, 1'b0});
    assign odd_idx   = COUNT_W'({row_reg, 1'b1});
    assign even_hit  = (mem_rd_data[ENTRY_W-1:0] == '0) && (even_idx < count_reg);
    assign odd_hit   = (mem_rd_data[ROW_DATA_W-1:ENTRY_W] == '0) && (odd_idx < count_reg);
    assign scan_last = ((even_idx + COUNT_W'(2)) >= count_reg) || (row_reg == ROW_LAST);

    always_comb
    begin
        unique case (lane)
            2'd0:
            begin
                lane_byte   = mem_rd_data[7:0];
                byte_merged = {mem_rd_data[23:8], data_reg};
            end
            2'd1:
            begin
                lane_byte   = mem_rd_data[15:8];
                byte_merged = {mem_rd_data[23:16], data_reg, mem_rd_data[7:0]};
            end
            2'd2:
            begin
                lane_byte   = mem_rd_data[23:16];
                byte_merged = {data_reg, mem_rd_data[15:0]};
            end
            default:
            begin
                lane_byte   = '0;
                byte_merged = mem_rd_data;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        odd_reg   <= odd_next;
        value_reg <= value_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        row_reg   <= row_next;
    end

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        odd_next   = odd_reg;
        value_next = value_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        row_next   = row_reg;
        in_ready   = 1'b0;
        mem_req    = '0;
        res_valid  = 1'b0;
        res        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    act_next    = in_item.action;
                    odd_next    = in_item.cluster[0];
                    value_next  = in_item.next_value;
                    addr_next   = in_item.byte_addr;
                    data_next   = in_item.byte_data;
                    mem_req.rd_en = 1'b1;
                    if (in_item.action == ACT_ALLOCATE)
                    begin
                        row_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        if (in_item.action == ACT_WRITE_BYTE ||
                            in_item.action == ACT_READ_BYTE)
                        begin
                            row_next = in_byte_row;
                        end
                        else
                        begin
                            row_next = in_item.cluster[ENTRY_W-1:1];
                        end
                        state_next = ST_EXEC;
                    end
                    mem_req.addr = row_next;
                end
            end

            ST_EXEC:
            begin
                mem_req.addr = row_reg;
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    unique case (act_reg)
                        ACT_READ_ENTRY:
                        begin
                            res.entry_value = odd_reg ? mem_rd_data[ROW_DATA_W-1:ENTRY_W]
                                                      : mem_rd_data[ENTRY_W-1:0];
                        end
                        ACT_WRITE_ENTRY:
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_data = odd_reg ? {value_reg, mem_rd_data[ENTRY_W-1:0]}
                                                      : {mem_rd_data[ROW_DATA_W-1:ENTRY_W],
                                                         value_reg};
                        end
                        ACT_WRITE_BYTE:
                        begin
                            mem_req.wr_en   = addr_ok;
                            mem_req.wr_data = byte_merged;
                        end
                        ACT_READ_BYTE:
                        begin
                            res.byte_out = addr_ok ? lane_byte : '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                mem_req.addr = row_reg;
                priority if (even_hit || odd_hit)
                begin
                    if (slot_free)
                    begin
                        res_valid           = 1'b1;
                        res.found           = 1'b1;
                        res.allocated_index = even_hit ? even_idx[ENTRY_W-1:0]
                                                       : odd_idx[ENTRY_W-1:0];
                        mem_req.wr_en       = 1'b1;
                        mem_req.wr_data     = even_hit
                            ? {mem_rd_data[ROW_DATA_W-1:ENTRY_W], CLAIM_MARK}
                            : {CLAIM_MARK, mem_rd_data[ENTRY_W-1:0]};
                        state_next          = ST_IDLE;
                    end
                end
                else if (scan_last)
                begin
                    if (slot_free)
                    begin
                        res_valid  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    row_next      = row_reg + ROW_W'(1);
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = row_next;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/fat12_cte_obuf.sv -----
// ----------------------------------------------------------------------------
// fat12_cte_obuf
// Result register between the sequencer and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cte_obuf
    import fat12_cte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        res_valid,
    input  wire res_t        res,
    output logic             slot_free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic [0:0]       m_tuser
);

    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg, out_res_next;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (slot_free)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.byte_out, out_res_reg.allocated_index,
                       out_res_reg.entry_value};
    assign m_tuser  = out_res_reg.found;

endmodule

`default_nettype wire

// ----- rtl/fat12_cte_checker.sv -----
// ----------------------------------------------------------------------------
// fat12_cte_checker
// Port-level checks of the FAT12 cluster table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cte_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_no_index_without_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[23:12] == 12'd0)
        else $error("allocated index set without found");

    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[11:0] == 12'd0 && m_tdata[31:24] == 8'd0)
        else $error("allocate result carries entry or byte data");

endmodule

bind fat12_cluster_table_engine_unit fat12_cte_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
